### src/darq_pkg.sv
// ----------------------------------------------------------------------------
// darq_pkg: shared types and codes of the deduplicating aging request queue
// Holds request action codes, result status codes, the controller state type
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package darq_pkg;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_DUP       = 2'd2;
  localparam logic [1:0] ST_FULLEMPTY = 2'd3;

  localparam logic [4:0]  DROP_MAX      = 5'd31;
  localparam logic [31:0] TIMEOUT_RESET = 32'd30;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_POP_RD,
    S_POP_CHK,
    S_FIN
  } ctl_state_t;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic push_exec;
    logic rd_issue;
    logic pop_step;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_action;
    logic empty;
    logic stale;
    logic out_free;
  } ctl_sts_t;

endpackage

### src/darq_req_if.sv
// ----------------------------------------------------------------------------
// darq_req_if: request channel of the request queue
// Valid/ready handshake carrying one push or pop request with its time.
// ----------------------------------------------------------------------------
interface darq_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  request_kind;
  logic [31:0] now_time;

  modport source (output valid, action, request_kind, now_time, input ready);
  modport sink (input valid, action, request_kind, now_time, output ready);
endinterface

### src/darq_rsp_if.sv
// ----------------------------------------------------------------------------
// darq_rsp_if: result channel of the request queue
// Valid/ready handshake carrying the outcome of one request.
// ----------------------------------------------------------------------------
interface darq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  popped_kind;
  logic [31:0] popped_stamp;
  logic [4:0]  stale_dropped;

  modport source (output valid, status, popped_kind, popped_stamp, stale_dropped,
                  input ready);
  modport sink (input valid, status, popped_kind, popped_stamp, stale_dropped,
                output ready);
endinterface

### src/darq_ram.sv
// ----------------------------------------------------------------------------
// darq_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module darq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/darq_ctrl.sv
// ----------------------------------------------------------------------------
// darq_ctrl: sequencer of the request queue
// Accepts one request at a time, runs a push in one step or walks the head
// of the queue on a pop, then hands the result to the output register.
// ----------------------------------------------------------------------------
module darq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  darq_pkg::ctl_sts_t sts,
  output darq_pkg::ctl_cmd_t cmd
);

  darq_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= darq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      darq_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (sts.in_action == darq_pkg::ACT_POP) ? darq_pkg::S_POP_RD
                                                             : darq_pkg::S_PUSH;
        end
      end
      darq_pkg::S_PUSH: begin
        cmd.push_exec = 1'b1;
        state_nxt     = darq_pkg::S_FIN;
      end
      darq_pkg::S_POP_RD: begin
        if (sts.empty) begin
          state_nxt = darq_pkg::S_FIN;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = darq_pkg::S_POP_CHK;
        end
      end
      darq_pkg::S_POP_CHK: begin
        cmd.pop_step = 1'b1;
        state_nxt    = sts.stale ? darq_pkg::S_POP_RD : darq_pkg::S_FIN;
      end
      darq_pkg::S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = darq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = darq_pkg::S_IDLE;
      end
    endcase
  end

  a_rd_then_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |=> cmd.pop_step)
    else $error("read issued without a following head check");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a waiting result");

  a_accept_then_work: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (cmd.push_exec || state_r == darq_pkg::S_POP_RD))
    else $error("accepted request not started");

endmodule

### src/darq_dp.sv
// ----------------------------------------------------------------------------
// darq_dp: datapath of the request queue
// Slot memory, head and tail pointers, per-type presence flags, timeout
// register, result assembly and the output register.
// ----------------------------------------------------------------------------
module darq_dp #(
  parameter int QUEUE_SLOTS = 32,
  parameter int KIND_COUNT  = 8,
  localparam int IW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1,
  localparam int KW = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  darq_pkg::ctl_cmd_t cmd,
  output darq_pkg::ctl_sts_t sts,
  input  logic               in_valid,
  input  logic               in_action,
  input  logic [7:0]         in_request_kind,
  input  logic [31:0]        in_now_time,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [7:0]         out_popped_kind,
  output logic [31:0]        out_popped_stamp,
  output logic [4:0]         out_stale_dropped
);

  localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_SLOTS - 1);
  localparam logic [8:0]    KIND_LIM  = 9'(KIND_COUNT);

  logic [31:0]           timeout_r;
  logic [IW-1:0]         head_r, tail_r;
  logic [KIND_COUNT-1:0] present_r;
  logic [7:0]            req_kind_r;
  logic [31:0]           req_now_r;
  logic [1:0]            res_status_r;
  logic [7:0]            res_kind_r;
  logic [31:0]           res_stamp_r;
  logic [4:0]            drop_r;
  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [7:0]            out_kind_r;
  logic [31:0]           out_stamp_r;
  logic [4:0]            out_drop_r;

  logic [IW-1:0] head_inc, tail_inc;
  logic          full;
  logic [1:0]    push_status;
  logic [KW-1:0] push_kidx, pop_kidx;
  logic [39:0]   rd_data;
  logic [7:0]    rd_kind;
  logic [31:0]   rd_stamp;
  logic [31:0]   age;
  logic          stale;
  logic          out_free;

  assign head_inc  = (head_r == LAST_SLOT) ? '0 : head_r + IW'(1);
  assign tail_inc  = (tail_r == LAST_SLOT) ? '0 : tail_r + IW'(1);
  assign full      = (tail_inc == head_r);
  assign push_kidx = req_kind_r[KW-1:0];
  assign rd_kind   = rd_data[39:32];
  assign rd_stamp  = rd_data[31:0];
  assign pop_kidx  = rd_kind[KW-1:0];
  assign age       = req_now_r - rd_stamp;
  assign stale     = (age > timeout_r);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    if ({1'b0, req_kind_r} >= KIND_LIM) begin
      push_status = darq_pkg::ST_RANGE;
    end else if (present_r[push_kidx]) begin
      push_status = darq_pkg::ST_DUP;
    end else if (full) begin
      push_status = darq_pkg::ST_FULLEMPTY;
    end else begin
      push_status = darq_pkg::ST_OK;
    end
  end

  darq_ram #(
    .WIDTH (40),
    .DEPTH (QUEUE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.push_exec && (push_status == darq_pkg::ST_OK)),
    .waddr (tail_r),
    .wdata ({req_kind_r, req_now_r}),
    .re    (cmd.rd_issue),
    .raddr (head_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= darq_pkg::TIMEOUT_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (cmd.push_exec && (push_status == darq_pkg::ST_OK)) begin
        tail_r              <= tail_inc;
        present_r[push_kidx] <= 1'b1;
      end
      if (cmd.pop_step) begin
        head_r              <= head_inc;
        present_r[pop_kidx] <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_kind_r   <= in_request_kind;
      req_now_r    <= in_now_time;
      res_status_r <= darq_pkg::ST_FULLEMPTY;
      res_kind_r   <= '0;
      res_stamp_r  <= '0;
      drop_r       <= '0;
    end
    if (cmd.push_exec) begin
      res_status_r <= push_status;
    end
    if (cmd.pop_step) begin
      if (stale) begin
        if (drop_r != darq_pkg::DROP_MAX) begin
          drop_r <= drop_r + 5'd1;
        end
      end else begin
        res_status_r <= darq_pkg::ST_OK;
        res_kind_r   <= rd_kind;
        res_stamp_r  <= rd_stamp;
      end
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_kind_r   <= res_kind_r;
      out_stamp_r  <= res_stamp_r;
      out_drop_r   <= drop_r;
    end
  end

  assign sts.in_valid  = in_valid;
  assign sts.in_action = in_action;
  assign sts.empty     = (head_r == tail_r);
  assign sts.stale     = stale;
  assign sts.out_free  = out_free;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_popped_kind   = out_kind_r;
  assign out_popped_stamp  = out_stamp_r;
  assign out_stale_dropped = out_drop_r;

  logic [IW:0] occupancy;
  assign occupancy = (tail_r >= head_r) ? {1'b0, tail_r} - {1'b0, head_r}
                                        : {1'b0, tail_r} + (IW+1)'(QUEUE_SLOTS)
                                          - {1'b0, head_r};

  a_presence_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(present_r) == int'(occupancy))
    else $error("presence flags disagree with queue occupancy");

  a_step_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_step |-> (head_r != tail_r))
    else $error("head advanced on an empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_exec && push_status == darq_pkg::ST_OK) |=> (tail_r != head_r))
    else $error("successful push left the queue empty");

endmodule

### src/dedup_aging_request_queue.sv
// ----------------------------------------------------------------------------
// dedup_aging_request_queue: deduplicating ring-buffer request queue with aging
// A push runs one push step before its result is loaded; a pop walks the head
// of the queue, dropping D stale entries before it finds a live one or ends empty,
// and each head entry needs one slot memory read and one check step.
// One request is in flight at a time; the next is accepted while a result waits.
// Synchronous active-low reset empties the queue and sets the timeout to 30.
// Per-type presence flags answer the duplicate check combinationally.
// ----------------------------------------------------------------------------
module dedup_aging_request_queue #(
  parameter int QUEUE_SLOTS = 32,
  parameter int KIND_COUNT  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  darq_req_if.sink    in_req,
  darq_rsp_if.source  out_rsp,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  darq_pkg::ctl_cmd_t cmd;
  darq_pkg::ctl_sts_t sts;

  darq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  darq_dp #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .KIND_COUNT  (KIND_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_valid          (in_req.valid),
    .in_action         (in_req.action),
    .in_request_kind   (in_req.request_kind),
    .in_now_time       (in_req.now_time),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_ready         (out_rsp.ready),
    .out_valid         (out_rsp.valid),
    .out_status        (out_rsp.status),
    .out_popped_kind   (out_rsp.popped_kind),
    .out_popped_stamp  (out_rsp.popped_stamp),
    .out_stale_dropped (out_rsp.stale_dropped)
  );

  assign in_req.ready = cmd.in_ready;

endmodule

### tb/darq_checker.sv
// ----------------------------------------------------------------------------
// darq_checker: result predictor and scoreboard for the request queue
// Follows every accepted request and timeout write and keeps its own copy of
// the ring buffer. It predicts the outcome of each request and compares
// every delivered result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module darq_checker
  import darq_pkg::*;
#(
  parameter int QUEUE_SLOTS = 32,
  parameter int KIND_COUNT  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  darq_req_if         req,
  darq_rsp_if         rsp,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output int          fail_count,
  output int          pending,
  output int          stale_total
);

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  kind;
    logic [31:0] stamp;
    logic [4:0]  dropped;
  } outcome_t;

  logic [7:0]  entry_kind [QUEUE_SLOTS];
  logic [31:0] entry_stamp [QUEUE_SLOTS];
  int          head;
  int          tail;
  logic [31:0] timeout;
  outcome_t    outcome_q [$];

  function automatic int next_slot(int idx);
    return (idx == QUEUE_SLOTS - 1) ? 0 : idx + 1;
  endfunction

  function automatic outcome_t predict_outcome(logic act, logic [7:0] kind,
                                               logic [31:0] now);
    outcome_t    res;
    logic        queued;
    logic [31:0] age;
    res = '0;
    res.status = ST_FULLEMPTY;
    if (act == ACT_PUSH) begin
      queued = 1'b0;
      for (int i = head; i != tail; i = next_slot(i)) begin
        if (entry_kind[i] == kind) queued = 1'b1;
      end
      if (kind >= KIND_COUNT) begin
        res.status = ST_RANGE;
      end else if (queued) begin
        res.status = ST_DUP;
      end else if (next_slot(tail) != head) begin
        entry_kind[tail] = kind;
        entry_stamp[tail] = now;
        tail = next_slot(tail);
        res.status = ST_OK;
      end
    end else begin
      while (head != tail && res.status != ST_OK) begin
        age = now - entry_stamp[head];
        if (age > timeout) begin
          if (res.dropped != DROP_MAX) res.dropped = res.dropped + 5'd1;
        end else begin
          res.kind = entry_kind[head];
          res.stamp = entry_stamp[head];
          res.status = ST_OK;
        end
        head = next_slot(head);
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
    if (got_val !== exp_val) begin
      fail_count++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      head = 0;
      tail = 0;
      timeout = TIMEOUT_RESET;
      outcome_q.delete();
      fail_count = 0;
      pending = 0;
      stale_total = 0;
    end else begin
      if (cfg_wr_en) timeout = cfg_wr_data;
      if (req.valid && req.ready) begin
        outcome_q.push_back(predict_outcome(req.action, req.request_kind, req.now_time));
      end
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with status %0d arrived with no request outstanding",
                   $time, rsp.status);
        end else begin
          want = outcome_q.pop_front();
          stale_total += want.dropped;
          check_field("status", 32'(want.status), 32'(rsp.status));
          check_field("popped_kind", 32'(want.kind), 32'(rsp.popped_kind));
          check_field("popped_stamp", want.stamp, rsp.popped_stamp);
          check_field("stale_dropped", 32'(want.dropped), 32'(rsp.stale_dropped));
        end
      end
      pending = outcome_q.size();
    end
  end

endmodule

### tb/dedup_aging_request_queue_test.sv
// ----------------------------------------------------------------------------
// dedup_aging_request_queue_test: top of the request queue testbench
// Runs directed pushes and pops over range faults, duplicates, aging and time
// wrap, then random request sequences under several timeout settings with
// random stalls on both channels in all but two phases. The checker judges every result.
// ----------------------------------------------------------------------------
module dedup_aging_request_queue_test;
  import darq_pkg::*;

  localparam int QUEUE_SLOTS = 32;
  localparam int KIND_COUNT  = 8;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_ITEMS = 180;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        calm;
  int          fail_count;
  int          pending;
  int          stale_total;
  int          push_count;
  int          pop_count;

  darq_req_if req_ch ();
  darq_rsp_if rsp_ch ();

  dedup_aging_request_queue #(
    .QUEUE_SLOTS(QUEUE_SLOTS),
    .KIND_COUNT (KIND_COUNT)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (req_ch),
    .out_rsp    (rsp_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  darq_checker #(
    .QUEUE_SLOTS(QUEUE_SLOTS),
    .KIND_COUNT (KIND_COUNT)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending),
    .stale_total(stale_total)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic send_request(logic act, logic [7:0] kind, logic [31:0] now);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= act;
    req_ch.request_kind <= kind;
    req_ch.now_time <= now;
    if (act == ACT_PUSH) push_count++;
    else pop_count++;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic drain_results(int settle);
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_timeout(logic [31:0] value);
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [31:0] timeouts [PHASE_COUNT];
    logic [31:0] clock_now;
    logic [31:0] step_max;
    logic        act;
    logic [7:0]  kind;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_PUSH;
    req_ch.request_kind = 8'd0;
    req_ch.now_time = 32'd0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 32'd0;
    calm = 1'b0;
    push_count = 0;
    pop_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset timeout of 30.
    send_request(ACT_POP, 8'd0, 32'd100);
    send_request(ACT_PUSH, 8'd8, 32'd100);
    send_request(ACT_PUSH, 8'd255, 32'd100);
    send_request(ACT_PUSH, 8'd0, 32'd0);
    send_request(ACT_PUSH, 8'd0, 32'd1);
    send_request(ACT_PUSH, 8'd7, 32'd5);
    send_request(ACT_PUSH, 8'd200, 32'd6);
    send_request(ACT_POP, 8'd0, 32'd30);
    send_request(ACT_POP, 8'd0, 32'd36);
    for (int k = 0; k < KIND_COUNT; k++) begin
      send_request(ACT_PUSH, 8'(k), 32'hFFFF_FFF0 + 32'(k));
    end
    send_request(ACT_PUSH, 8'd3, 32'hFFFF_FFF9);
    send_request(ACT_POP, 8'd0, 32'h0000_0010);
    send_request(ACT_POP, 8'd0, 32'hFFFF_FFF0);
    send_request(ACT_PUSH, 8'd1, 32'hFFFF_FFFF);
    send_request(ACT_POP, 8'd0, 32'hFFFF_FFFF);
    send_request(ACT_PUSH, 8'd4, 32'h8000_0000);
    send_request(ACT_POP, 8'd0, 32'h7FFF_FFFF);
    drain_results(25);

    timeouts[0] = 32'd0;
    timeouts[1] = 32'hFFFF_FFFF;
    timeouts[2] = 32'($urandom_range(1, 20));
    timeouts[3] = $urandom();
    timeouts[4] = 32'd30;
    timeouts[5] = 32'($urandom_range(100, 5000));
    timeouts[6] = 32'd1;
    timeouts[7] = 32'd30;
    clock_now = $urandom();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      write_timeout(timeouts[phase]);
      calm = (phase == 2 || phase == PHASE_COUNT - 1);
      step_max = timeouts[phase] / 4 + 32'd2;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom());
        end else begin
          if ($urandom_range(0, 24) == 0) begin
            clock_now += timeouts[phase] + 32'($urandom_range(1, 50));
          end else begin
            clock_now += 32'($urandom_range(0, step_max));
          end
          act = ($urandom_range(0, 99) < 55) ? ACT_PUSH : ACT_POP;
          if ($urandom_range(0, 9) == 0) kind = 8'($urandom_range(KIND_COUNT, 255));
          else kind = 8'($urandom_range(0, KIND_COUNT - 1));
          send_request(act, kind, clock_now);
        end
      end
      drain_results(25);
    end

    $display("Sent %0d pushes and %0d pops under %0d timeout settings.",
             push_count, pop_count, PHASE_COUNT + 1);
    $display("Predicted %0d stale entries dropped across all pops.", stale_total);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
